// ===== rtl/sabd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sabd_pkg: shared types and constants
// Field widths, register codes, reset values and the item and result records
// that pass between the front end, the averaging back end and the result queue.
// ----------------------------------------------------------------------------
package sabd_pkg;

	localparam int NUM_CH     = 3;
	localparam int CH_W       = 2;
	localparam int SMP_W      = 16;
	localparam int CUT_W      = 12;
	localparam int CUT_DROP   = 4;
	localparam int SUM_W      = 20;
	localparam int SCL_W      = 9;
	localparam int SCL_SHIFT  = 3;
	localparam int VAL_W      = 10;
	localparam int HOLD_W     = 8;
	localparam int LIM_W      = 8;
	localparam int OFS_W      = 9;
	localparam int DCNT_W     = 9;
	localparam int BTN_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	localparam logic [CH_W-1:0]   CH_FIRST   = 2'd0;
	localparam logic [CH_W-1:0]   CH_LAST    = 2'd2;
	localparam logic [HOLD_W-1:0] HOLD_RST   = 8'd100;
	localparam logic [LIM_W-1:0]  LIMIT_RST  = 8'd10;
	localparam logic [OFS_W-1:0]  OFFSET_RST = 9'd100;
	localparam logic [VAL_W-1:0]  REPORT_RST = 10'd200;
	localparam logic [DCNT_W-1:0] DCNT_MAX   = 9'd511;

	typedef enum logic [BTN_W-1:0] {
		BTN_NONE   = 3'd0,
		BTN_DOWN   = 3'd1,
		BTN_LEFT   = 3'd2,
		BTN_SELECT = 3'd3,
		BTN_UP     = 3'd4,
		BTN_RIGHT  = 3'd5
	} btn_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANGE_HOLD    = 2'd0,
		CFG_DEBOUNCE_LIMIT = 2'd1,
		CFG_VALUE_OFFSET   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [HOLD_W-1:0] change_hold;
		logic [LIM_W-1:0]  debounce_limit;
		logic [OFS_W-1:0]  value_offset;
	} cfg_t;

	// one tick after the front end: cut readings and the two button inputs
	typedef struct packed {
		logic [NUM_CH-1:0][CUT_W-1:0] cut;
		logic                         left;
		logic                         right;
	} tick_t;

	typedef struct packed {
		logic [NUM_CH-1:0][VAL_W-1:0] value;
		logic [NUM_CH-1:0]            changed;
		logic                         left_pressed;
		logic                         right_pressed;
		logic                         left_toggled;
		logic                         right_toggled;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/sabd_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sabd channel interfaces
// Valid/ready channels for input ticks, results and register writes.
// ----------------------------------------------------------------------------
interface sabd_item_if;
	logic                         valid;
	logic                         ready;
	logic [sabd_pkg::SMP_W-1:0]   sample_a;
	logic [sabd_pkg::SMP_W-1:0]   sample_b;
	logic [sabd_pkg::SMP_W-1:0]   sample_c;
	logic [sabd_pkg::BTN_W-1:0]   button_code;

	modport source(output valid, output sample_a, output sample_b, output sample_c,
		output button_code, input ready);
	modport sink(input valid, input sample_a, input sample_b, input sample_c,
		input button_code, output ready);
endinterface

interface sabd_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [sabd_pkg::VAL_W-1:0]  value_a;
	logic signed [sabd_pkg::VAL_W-1:0]  value_b;
	logic signed [sabd_pkg::VAL_W-1:0]  value_c;
	logic                               changed_a;
	logic                               changed_b;
	logic                               changed_c;
	logic                               left_pressed;
	logic                               right_pressed;
	logic                               left_toggled;
	logic                               right_toggled;

	modport source(output valid, output value_a, output value_b, output value_c,
		output changed_a, output changed_b, output changed_c, output left_pressed,
		output right_pressed, output left_toggled, output right_toggled, input ready);
	modport sink(input valid, input value_a, input value_b, input value_c,
		input changed_a, input changed_b, input changed_c, input left_pressed,
		input right_pressed, input left_toggled, input right_toggled, output ready);
endinterface

interface sabd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [sabd_pkg::CFG_IDX_W-1:0]    index;
	logic [sabd_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sabd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sabd_front: tick intake
// Accepts ticks, cuts the readings to 12 bits, decodes the button code and
// holds up to two ticks for the back end.
// ----------------------------------------------------------------------------
module sabd_front (
	input  logic              clk,
	input  logic              arst_n,
	sabd_item_if.sink         item,
	output logic              head_valid,
	output sabd_pkg::tick_t   head,
	input  logic              pop
);

	sabd_pkg::tick_t q_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	sabd_pkg::tick_t entry;

	assign item.ready = (cnt_q != 2'd2);
	assign push       = item.valid && item.ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_q[rd_ptr_q];

	always_comb begin
		entry.cut[0] = item.sample_a[sabd_pkg::SMP_W-1:sabd_pkg::CUT_DROP];
		entry.cut[1] = item.sample_b[sabd_pkg::SMP_W-1:sabd_pkg::CUT_DROP];
		entry.cut[2] = item.sample_c[sabd_pkg::SMP_W-1:sabd_pkg::CUT_DROP];
		// unused codes count as neither button
		entry.left   = (item.button_code == sabd_pkg::BTN_LEFT);
		entry.right  = (item.button_code == sabd_pkg::BTN_RIGHT);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sabd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sabd_back: averaging and debounce engine
// Walks the three channels of a tick through one shared sample memory, keeps
// the running sums, scales the average, applies persistence and debounces
// the buttons. A result leaves on the last channel of each tick.
// ----------------------------------------------------------------------------
module sabd_back #(
	parameter int WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sabd_pkg::tick_t     head,
	input  logic                space,
	input  sabd_pkg::cfg_t      cfg,
	output logic                start,
	output logic                push,
	output sabd_pkg::result_t   res
);

	localparam int PTR_W   = $clog2(WINDOW);
	localparam int AW      = $clog2(sabd_pkg::NUM_CH * WINDOW);
	localparam int SHIFT   = sabd_pkg::SUM_W + PTR_W;
	localparam int RECIP_W = sabd_pkg::SUM_W + 1;
	localparam int PROD_W  = sabd_pkg::SUM_W + RECIP_W;
	localparam int SCL_LSB = SHIFT + sabd_pkg::SCL_SHIFT;
	// exact floor division of any 20-bit sum by WINDOW
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(WINDOW - 1);

	// sequencer
	logic                            busy_q;
	logic [sabd_pkg::CH_W-1:0]       ch_q;
	logic [PTR_W-1:0]                ptr_q;
	logic                            wrapped_q;
	sabd_pkg::tick_t                 cur_q;
	logic                            issue;
	logic                            issue_last;
	logic [sabd_pkg::CH_W-1:0]       issue_ch;
	logic [sabd_pkg::CUT_W-1:0]      issue_cut;
	logic [AW-1:0]                   rd_addr;

	logic [sabd_pkg::CUT_W-1:0]      mem_q [sabd_pkg::NUM_CH * WINDOW];

	// stage 1: memory read data
	logic                            vld_s1;
	logic [sabd_pkg::CH_W-1:0]       ch_s1;
	logic [sabd_pkg::CUT_W-1:0]      cut_s1;
	logic [AW-1:0]                   addr_s1;
	logic                            old_ok_s1;
	logic                            last_s1;
	logic [1:0]                      btn_s1;
	logic [sabd_pkg::CUT_W-1:0]      rd_s1;
	logic [sabd_pkg::CUT_W-1:0]      old_val;
	logic [sabd_pkg::SUM_W-1:0]      sum_new;
	logic [sabd_pkg::SUM_W-1:0]      sums_q [sabd_pkg::NUM_CH];

	// stage 2: updated sum
	logic                            vld_s2;
	logic [sabd_pkg::CH_W-1:0]       ch_s2;
	logic                            last_s2;
	logic [1:0]                      btn_s2;
	logic [sabd_pkg::SUM_W-1:0]      sum_s2;
	logic [PROD_W-1:0]               prod;

	// stage 3: scaled average
	logic                            vld_s3;
	logic [sabd_pkg::CH_W-1:0]       ch_s3;
	logic                            last_s3;
	logic [1:0]                      btn_s3;
	logic [sabd_pkg::SCL_W-1:0]      scaled_s3;
	logic [sabd_pkg::VAL_W-1:0]      v;
	logic                            differ;
	logic                            take;

	logic [sabd_pkg::VAL_W-1:0]      rep_q  [sabd_pkg::NUM_CH];
	logic [sabd_pkg::HOLD_W-1:0]     pers_q [sabd_pkg::NUM_CH];
	logic [sabd_pkg::NUM_CH-1:0]     chg_q;
	logic [1:0]                      btn_st_q;
	logic [sabd_pkg::DCNT_W-1:0]     dcnt_q [2];
	logic [1:0]                      flip;
	logic [1:0]                      btn_st_next;
	logic [sabd_pkg::DCNT_W-1:0]     dcnt_next [2];

	// ---------------- issue ----------------
	assign start      = !busy_q && head_valid && space;
	assign issue      = start || busy_q;
	assign issue_ch   = start ? sabd_pkg::CH_FIRST : ch_q;
	assign issue_cut  = start ? head.cut[0] : cur_q.cut[ch_q];
	assign issue_last = busy_q && (ch_q == sabd_pkg::CH_LAST);
	assign rd_addr    = AW'(issue_ch) * AW'(WINDOW) + AW'(ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			ch_q      <= sabd_pkg::CH_FIRST;
			ptr_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				ch_q   <= sabd_pkg::CH_FIRST + 2'd1;
			end else if (busy_q) begin
				if (issue_last) begin
					busy_q <= 1'b0;
					ch_q   <= sabd_pkg::CH_FIRST;
					if (ptr_q == PTR_LAST) begin
						ptr_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end else begin
					ch_q <= ch_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q <= head;
		end
	end

	// ---------------- sample memory ----------------
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem_q[addr_s1] <= cut_s1;
		end
		if (issue) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		ch_s1     <= issue_ch;
		cut_s1    <= issue_cut;
		addr_s1   <= rd_addr;
		// entries are valid only once the ring has come around
		old_ok_s1 <= wrapped_q;
		last_s1   <= issue_last;
		btn_s1    <= {cur_q.right, cur_q.left};
	end

	// ---------------- running sum ----------------
	assign old_val = old_ok_s1 ? rd_s1 : '0;
	assign sum_new = sums_q[ch_s1] - sabd_pkg::SUM_W'(old_val) + sabd_pkg::SUM_W'(cut_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sabd_pkg::NUM_CH; i++) begin
				sums_q[i] <= '0;
			end
		end else if (vld_s1) begin
			sums_q[ch_s1] <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		ch_s2   <= ch_s1;
		last_s2 <= last_s1;
		btn_s2  <= btn_s1;
		sum_s2  <= sum_new;
	end

	// ---------------- scaling ----------------
	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		ch_s3     <= ch_s2;
		last_s3   <= last_s2;
		btn_s3    <= btn_s2;
		scaled_s3 <= prod[SCL_LSB +: sabd_pkg::SCL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// ---------------- persistence ----------------
	assign v      = {1'b0, scaled_s3} - {1'b0, cfg.value_offset};
	assign differ = (v != rep_q[ch_s3]);
	assign take   = differ && (pers_q[ch_s3] >= cfg.change_hold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sabd_pkg::NUM_CH; i++) begin
				rep_q[i]  <= sabd_pkg::REPORT_RST;
				pers_q[i] <= '0;
			end
		end else if (vld_s3) begin
			if (!differ) begin
				pers_q[ch_s3] <= '0;
			end else if (take) begin
				pers_q[ch_s3] <= '0;
				rep_q[ch_s3]  <= v;
			end else begin
				pers_q[ch_s3] <= pers_q[ch_s3] + sabd_pkg::HOLD_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			chg_q[ch_s3] <= take;
		end
	end

	// ---------------- debounce ----------------
	always_comb begin
		logic [sabd_pkg::DCNT_W-1:0] inc;
		for (int b = 0; b < 2; b++) begin
			inc            = (dcnt_q[b] != sabd_pkg::DCNT_MAX) ?
				dcnt_q[b] + sabd_pkg::DCNT_W'(1) : dcnt_q[b];
			flip[b]        = 1'b0;
			btn_st_next[b] = btn_st_q[b];
			dcnt_next[b]   = dcnt_q[b];
			// counter holds its value on agreeing ticks
			if (btn_s3[b] != btn_st_q[b]) begin
				if (inc > {1'b0, cfg.debounce_limit}) begin
					flip[b]        = 1'b1;
					btn_st_next[b] = btn_s3[b];
					dcnt_next[b]   = '0;
				end else begin
					dcnt_next[b] = inc;
				end
			end
		end
	end

	assign push = vld_s3 && last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			btn_st_q  <= 2'b00;
			dcnt_q[0] <= '0;
			dcnt_q[1] <= '0;
		end else if (push) begin
			btn_st_q  <= btn_st_next;
			dcnt_q[0] <= dcnt_next[0];
			dcnt_q[1] <= dcnt_next[1];
		end
	end

	// ---------------- result ----------------
	always_comb begin
		for (int k = 0; k < sabd_pkg::NUM_CH; k++) begin
			if (ch_s3 == sabd_pkg::CH_W'(k)) begin
				res.value[k]   = take ? v : rep_q[k];
				res.changed[k] = take;
			end else begin
				res.value[k]   = rep_q[k];
				res.changed[k] = chg_q[k];
			end
		end
		res.left_pressed  = btn_st_next[0];
		res.right_pressed = btn_st_next[1];
		res.left_toggled  = flip[0];
		res.right_toggled = flip[1];
	end

endmodule
`default_nettype wire

// ===== rtl/sabd_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sabd_outq: result queue
// Holds finished results until taken and hands out slots ahead of time so
// the back end never has to stall mid-tick.
// ----------------------------------------------------------------------------
module sabd_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                reserve,
	input  logic                push,
	input  sabd_pkg::result_t   din,
	output logic                space,
	sabd_result_if.source       result
);

	sabd_pkg::result_t                 q_q [sabd_pkg::OQ_DEPTH];
	logic [sabd_pkg::OQ_PTR_W-1:0]     wr_ptr_q;
	logic [sabd_pkg::OQ_PTR_W-1:0]     rd_ptr_q;
	logic [sabd_pkg::OQ_CNT_W-1:0]     cnt_q;
	logic [sabd_pkg::OQ_CNT_W-1:0]     rsv_q;
	logic                              pop;
	sabd_pkg::result_t                 head;

	assign pop   = result.valid && result.ready;
	assign space = (rsv_q < sabd_pkg::OQ_CNT_W'(sabd_pkg::OQ_DEPTH));
	assign head  = q_q[rd_ptr_q];

	assign result.valid         = (cnt_q != '0);
	assign result.value_a       = head.value[0];
	assign result.value_b       = head.value[1];
	assign result.value_c       = head.value[2];
	assign result.changed_a     = head.changed[0];
	assign result.changed_b     = head.changed[1];
	assign result.changed_c     = head.changed[2];
	assign result.left_pressed  = head.left_pressed;
	assign result.right_pressed = head.right_pressed;
	assign result.left_toggled  = head.left_toggled;
	assign result.right_toggled = head.right_toggled;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			rsv_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + sabd_pkg::OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sabd_pkg::OQ_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + sabd_pkg::OQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - sabd_pkg::OQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
			// slots held by ticks in flight plus results waiting
			unique case ({reserve, pop})
				2'b10:   rsv_q <= rsv_q + sabd_pkg::OQ_CNT_W'(1);
				2'b01:   rsv_q <= rsv_q - sabd_pkg::OQ_CNT_W'(1);
				default: rsv_q <= rsv_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sensor_average_and_button_debounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_average_and_button_debounce: three-channel averager with buttons
// Moving average over WINDOW samples per channel with change persistence,
// plus debounced left and right buttons.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     handshake
//  item     in   sample_a/b/c, button_code                   valid/ready
//  result   out  value_a/b/c, changed_a/b/c, buttons         valid/ready
//  cfg      in   index, data                                 valid/ready
//
//  The back end issues a tick's channels in turn, one read and one write of
//  the shared sample memory each, through read, sum and scaling registers.
//  A tick starts only with a free slot in the 4-deep result queue, and the
//  2-deep intake queue keeps taking ticks meanwhile. Reset clears sums, ring
//  position, persistence and debounce state at once; sample entries read as
//  zero until the ring has wrapped, so no clear pass.
// ----------------------------------------------------------------------------
module sensor_average_and_button_debounce #(
	parameter int WINDOW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	sabd_item_if.sink     item,
	sabd_result_if.source result,
	sabd_cfg_if.sink      cfg
);

	sabd_pkg::cfg_t      cfg_q;
	sabd_pkg::tick_t     head;
	sabd_pkg::result_t   res;
	logic                head_valid;
	logic                start;
	logic                push;
	logic                space;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_hold    <= sabd_pkg::HOLD_RST;
			cfg_q.debounce_limit <= sabd_pkg::LIMIT_RST;
			cfg_q.value_offset   <= sabd_pkg::OFFSET_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				sabd_pkg::CFG_CHANGE_HOLD: begin
					cfg_q.change_hold <= cfg.data[sabd_pkg::HOLD_W-1:0];
				end
				sabd_pkg::CFG_DEBOUNCE_LIMIT: begin
					cfg_q.debounce_limit <= cfg.data[sabd_pkg::LIM_W-1:0];
				end
				sabd_pkg::CFG_VALUE_OFFSET: begin
					cfg_q.value_offset <= cfg.data[sabd_pkg::OFS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sabd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (start)
	);

	sabd_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.space      (space),
		.cfg        (cfg_q),
		.start      (start),
		.push       (push),
		.res        (res)
	);

	sabd_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.reserve (start),
		.push    (push),
		.din     (res),
		.space   (space),
		.result  (result)
	);

	// a tick is only started from a held intake entry
	a_start_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> head_valid)
		else $error("tick started with empty intake queue");

	// no new tick starts while the channels of the last one are still issuing
	a_start_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !start ##1 !start)
		else $error("tick started before previous channels issued");

	// each tick start is followed by its result push
	a_start_to_push: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 push)
		else $error("result missing five cycles after tick start");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for sensor_average_and_button_debounce
// Drives ticks of three readings and a button code through valid/ready with
// bursty pacing and a stalling result sink. A scoreboard class follows every
// accepted tick, predicts the averaged values, persistence and debounce
// outcome, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
	import sabd_pkg::*;

	localparam int WINDOW = 64;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
	localparam logic [BTN_W-1:0] BTN_UNUSED_6 = 3'd6;
	localparam logic [BTN_W-1:0] BTN_UNUSED_7 = 3'd7;

	typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_LONG_STALLS} rdy_mode_t;

	class avg_button_sb;
		logic [CUT_W-1:0] ring [NUM_CH][WINDOW];
		int unsigned sums [NUM_CH];
		int unsigned slot;
		int reported [NUM_CH];
		int unsigned persist [NUM_CH];
		bit pressed [2];
		int unsigned bounce_cnt [2];
		int unsigned hold, limit, offset;
		result_t pending_results [$];
		int unsigned mismatches;

		function new();
			for (int ch = 0; ch < NUM_CH; ch++) begin
				for (int k = 0; k < WINDOW; k++)
					ring[ch][k] = '0;
				sums[ch] = 0;
				reported[ch] = int'(REPORT_RST);
				persist[ch] = 0;
			end
			slot = 0;
			pressed = '{0, 0};
			bounce_cnt = '{0, 0};
			hold = 32'(HOLD_RST);
			limit = 32'(LIMIT_RST);
			offset = 32'(OFFSET_RST);
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			CFG_CHANGE_HOLD: hold = 32'(data[HOLD_W-1:0]);
			CFG_DEBOUNCE_LIMIT: limit = 32'(data[LIM_W-1:0]);
			CFG_VALUE_OFFSET: offset = 32'(data[OFS_W-1:0]);
			default: ;
			endcase
		endfunction

		// counter keeps its value on agreeing ticks
		function bit debounce_step(int which, bit level);
			if (level != pressed[which]) begin
				if (bounce_cnt[which] < 32'(DCNT_MAX))
					bounce_cnt[which]++;
				if (bounce_cnt[which] > limit) begin
					bounce_cnt[which] = 0;
					pressed[which] = level;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_tick(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
			logic [SMP_W-1:0] c, logic [BTN_W-1:0] code);
			logic [SMP_W-1:0] raw [NUM_CH];
			logic [CUT_W-1:0] cut;
			int unsigned scaled;
			int v;
			result_t exp_res;
			raw = '{a, b, c};
			for (int ch = 0; ch < NUM_CH; ch++) begin
				cut = CUT_W'(raw[ch] >> CUT_DROP);
				sums[ch] = (sums[ch] - 32'(ring[ch][slot]) + 32'(cut)) & 32'hFFFFF;
				ring[ch][slot] = cut;
			end
			slot = (slot + 1) % WINDOW;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				scaled = ((sums[ch] / WINDOW) >> SCL_SHIFT) & 32'h1FF;
				v = int'(scaled) - int'(offset);
				exp_res.changed[ch] = 1'b0;
				if (v != reported[ch]) begin
					if (persist[ch] < hold) begin
						persist[ch]++;
					end else begin
						persist[ch] = 0;
						reported[ch] = v;
						exp_res.changed[ch] = 1'b1;
					end
				end else begin
					persist[ch] = 0;
				end
				exp_res.value[ch] = VAL_W'(reported[ch]);
			end
			exp_res.left_toggled = debounce_step(0, code == BTN_LEFT);
			exp_res.right_toggled = debounce_step(1, code == BTN_RIGHT);
			exp_res.left_pressed = pressed[0];
			exp_res.right_pressed = pressed[1];
			pending_results.push_back(exp_res);
		endfunction

		function void compare_field(string name, int exp_val, int act_val);
			if (exp_val != act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				mismatches++;
			end
		endfunction

		function void check_result(result_t got);
			result_t exp_res;
			if (pending_results.size() == 0) begin
				$error("result transfer with no tick pending");
				mismatches++;
				return;
			end
			exp_res = pending_results.pop_front();
			compare_field("value_a", $signed(exp_res.value[0]), $signed(got.value[0]));
			compare_field("value_b", $signed(exp_res.value[1]), $signed(got.value[1]));
			compare_field("value_c", $signed(exp_res.value[2]), $signed(got.value[2]));
			compare_field("changed_a", exp_res.changed[0], got.changed[0]);
			compare_field("changed_b", exp_res.changed[1], got.changed[1]);
			compare_field("changed_c", exp_res.changed[2], got.changed[2]);
			compare_field("left_pressed", exp_res.left_pressed, got.left_pressed);
			compare_field("right_pressed", exp_res.right_pressed, got.right_pressed);
			compare_field("left_toggled", exp_res.left_toggled, got.left_toggled);
			compare_field("right_toggled", exp_res.right_toggled, got.right_toggled);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sabd_item_if item_ch();
	sabd_result_if result_ch();
	sabd_cfg_if cfg_ch();

	sensor_average_and_button_debounce #(.WINDOW(WINDOW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	avg_button_sb sb = new();
	int unsigned burst_left = 0;
	rdy_mode_t rdy_mode = RDY_ALWAYS;
	int unsigned mode_left = 0;
	int unsigned stall_left = 0;

	always #2 clk = ~clk;

	initial begin
		#4000000;
		$display("sensor_average_and_button_debounce regression: fail");
		$finish;
	end

	// result sink: switches between random ready patterns
	always @(negedge clk) begin
		if (mode_left == 0) begin
			rdy_mode = rdy_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(20, 120);
		end else begin
			mode_left--;
		end
		case (rdy_mode)
		RDY_ALWAYS: result_ch.ready = 1'b1;
		RDY_MOSTLY: result_ch.ready = ($urandom_range(0, 3) != 0);
		RDY_RARELY: result_ch.ready = ($urandom_range(0, 3) == 0);
		default: begin
			if (stall_left == 0) begin
				result_ch.ready = ~result_ch.ready;
				stall_left = result_ch.ready ? $urandom_range(0, 4) : $urandom_range(1, 20);
			end else begin
				stall_left--;
			end
		end
		endcase
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.value[0] = result_ch.value_a;
			got.value[1] = result_ch.value_b;
			got.value[2] = result_ch.value_c;
			got.changed = {result_ch.changed_c, result_ch.changed_b, result_ch.changed_a};
			got.left_pressed = result_ch.left_pressed;
			got.right_pressed = result_ch.right_pressed;
			got.left_toggled = result_ch.left_toggled;
			got.right_toggled = result_ch.right_toggled;
			sb.check_result(got);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
		input logic [SMP_W-1:0] c, input logic [BTN_W-1:0] code);
		int unsigned gap;
		item_ch.valid = 1'b1;
		item_ch.sample_a = a;
		item_ch.sample_b = b;
		item_ch.sample_c = c;
		item_ch.button_code = code;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_tick(a, b, c, code);
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 60);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				item_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		item_ch.valid = 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg_port(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] hold_data,
		input logic [CFG_DATA_W-1:0] limit_data, input logic [CFG_DATA_W-1:0] offset_data);
		wait_idle();
		write_reg_port(CFG_CHANGE_HOLD, hold_data);
		write_reg_port(CFG_DEBOUNCE_LIMIT, limit_data);
		write_reg_port(CFG_VALUE_OFFSET, offset_data);
		// write to the unmapped index must change nothing
		write_reg_port(CFG_SPARE_IDX, 9'($urandom));
	endtask

	// segments of steady levels and a held button, with bounces and noise
	task automatic run_random(input int unsigned count);
		int unsigned levels [NUM_CH];
		int unsigned spread;
		int unsigned seg_left;
		int unsigned sent;
		logic [BTN_W-1:0] held;
		logic [SMP_W-1:0] s [NUM_CH];
		logic [BTN_W-1:0] code;
		seg_left = 0;
		sent = 0;
		while (sent < count) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(1, 48);
				for (int ch = 0; ch < NUM_CH; ch++)
					levels[ch] = $urandom_range(0, 16'hFFFF);
				case ($urandom_range(0, 3))
				0: spread = 0;
				1: spread = 16'h000F;
				2: spread = 16'h00FF;
				default: spread = 16'h0FFF;
				endcase
				case ($urandom_range(0, 9))
				0, 1, 2: held = BTN_LEFT;
				3, 4, 5: held = BTN_RIGHT;
				6: held = BTN_NONE;
				default: held = BTN_W'($urandom);
				endcase
			end
			seg_left--;
			if ($urandom_range(0, 9) == 0) begin
				for (int ch = 0; ch < NUM_CH; ch++)
					s[ch] = SMP_W'($urandom);
				code = BTN_W'($urandom);
			end else begin
				for (int ch = 0; ch < NUM_CH; ch++)
					s[ch] = SMP_W'(levels[ch] + $urandom_range(0, spread));
				code = ($urandom_range(0, 7) == 0) ? BTN_W'($urandom) : held;
			end
			send_item(s[0], s[1], s[2], code);
			sent++;
			if ($urandom_range(0, 149) == 0)
				wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.sample_a = '0;
		item_ch.sample_b = '0;
		item_ch.sample_c = '0;
		item_ch.button_code = BTN_NONE;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CHANGE_HOLD;
		cfg_ch.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings still in force
		send_item(16'h0000, 16'hFFFF, 16'h8000, BTN_NONE);
		send_item(16'hFFFF, 16'h0000, 16'h7FFF, BTN_LEFT);

		// immediate takeover and single-tick debounce
		apply_config(9'd0, 9'd0, 9'd0);
		send_item(16'h000F, 16'hFFF0, 16'h0010, BTN_LEFT);
		send_item(16'hFFF0, 16'h000F, 16'hFFEF, BTN_RIGHT);
		send_item(16'h5555, 16'hAAAA, 16'h0F0F, BTN_DOWN);
		send_item(16'hAAAA, 16'h5555, 16'hF0F0, BTN_SELECT);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, BTN_UP);
		send_item(16'h1234, 16'h8765, 16'hFEDC, BTN_UNUSED_6);
		send_item(16'h0000, 16'h0000, 16'h0000, BTN_UNUSED_7);
		send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, BTN_RIGHT);

		// debounce count survives agreeing ticks
		apply_config(9'd0, 9'd3, 9'd0);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_LEFT);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_NONE);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_LEFT);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_NONE);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_LEFT);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_NONE);
		send_item(16'hFFFF, 16'h8000, 16'h0000, BTN_LEFT);

		// offset above the average drives values negative; hold data wider than the field
		apply_config(9'h1FF, 9'd254, 9'd511);
		send_item(16'h0000, 16'hFFFF, 16'h0000, BTN_RIGHT);
		send_item(16'hFFFF, 16'h0000, 16'hFFFF, BTN_NONE);
		apply_config(9'd0, 9'd1, 9'd511);
		send_item(16'h0000, 16'hFFFF, 16'h0000, BTN_RIGHT);
		send_item(16'hFFFF, 16'h0000, 16'hFFFF, BTN_NONE);

		apply_config(9'd0, 9'd0, 9'd0);
		run_random(120);
		apply_config(9'd3, 9'd2, 9'd200);
		run_random(120);
		apply_config(9'd255, 9'd254, 9'd511);
		run_random(120);
		apply_config(9'($urandom_range(0, 20)), 9'($urandom_range(0, 12)),
			9'($urandom_range(0, 511)));
		run_random(120);
		apply_config(9'd1, 9'd1, 9'd0);
		run_random(120);
		apply_config(9'($urandom_range(0, 255)), 9'($urandom_range(0, 254)),
			9'($urandom_range(0, 511)));
		run_random(120);
		apply_config(9'(HOLD_RST), 9'(LIMIT_RST), 9'(OFFSET_RST));
		run_random(120);

		wait_idle();
		if (sb.mismatches == 0) begin
			$display("sensor_average_and_button_debounce regression: pass");
		end else begin
			$display("sensor_average_and_button_debounce regression: fail");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/sabd_pkg.sv
rtl/sabd_ifs.sv
rtl/sabd_front.sv
rtl/sabd_back.sv
rtl/sabd_outq.sv
rtl/sensor_average_and_button_debounce.sv
tb/sv/tb.sv
